>>> rtl/core/skc_pkg.sv
// Shared types and constants for the sorted key set.
// No dependencies; used by the interfaces, the cell and the top level.
package skc_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned EntryW   = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_SEARCH = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cap;  // capture compare flags against the incoming key
    logic ins;  // commit an insert
    logic del;  // commit a delete
  } cell_ctl_t;

endpackage

>>> rtl/core/skc_if.sv
// Valid/ready channel interfaces for the sorted key set.
// Depends on skc_pkg for payload widths.
interface skc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [skc_pkg::ModeW-1:0]             mode;
  logic signed [skc_pkg::KeyW-1:0]       key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface skc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [skc_pkg::StatusW-1:0]           status;
  logic [skc_pkg::EntryW-1:0]            entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

>>> rtl/core/skc_cell.sv
// One storage cell of the sorted key chain: holds a key, compares it with
// the broadcast key and shifts toward a neighbor. Depends on skc_pkg.
module skc_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  skc_pkg::cell_ctl_t              ctl_i,
  input  logic                            occ_i,
  input  logic signed [skc_pkg::KeyW-1:0] cmp_key_i,
  input  logic signed [skc_pkg::KeyW-1:0] new_key_i,
  input  logic signed [skc_pkg::KeyW-1:0] prev_key_i,
  input  logic                            prev_lt_i,
  input  logic signed [skc_pkg::KeyW-1:0] next_key_i,
  output logic signed [skc_pkg::KeyW-1:0] key_o,
  output logic                            lt_o,
  output logic                            eq_o
);

  logic signed [skc_pkg::KeyW-1:0] key_q, key_d;
  logic lt_q, eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctl_i.cap) begin
      lt_q <= occ_i && (key_q < cmp_key_i);
      eq_q <= occ_i && (key_q == cmp_key_i);
    end
  end

  // cells at or above the sorted position move; those below hold
  always_comb begin
    key_d = key_q;
    if (ctl_i.ins && !lt_q) begin
      key_d = prev_lt_i ? new_key_i : prev_key_i;
    end else if (ctl_i.del && !lt_q) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

>>> rtl/core/sorted_key_set.sv
// Sorted key set: a chain of CAPACITY cells holding unique signed keys in order.
// Result: registered at commit in S_UPD after the input beat is accepted; commit waits while a result is unread.
// Input beats: no new beat is taken until the current one commits (compare at accept, shift/commit in S_UPD),
// with the cell flag register between compare and update.
// Reset: count and handshake state clear at once; cell keys are left as is.
// Depends on skc_pkg, skc_if and skc_cell.
module sorted_key_set #(
  parameter int unsigned CAPACITY = skc_pkg::Capacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skc_in_if.sink     in_i,
  skc_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  skc_pkg::state_e state_q, state_d;
  skc_pkg::cell_ctl_t ctl;

  logic [CntW-1:0]                 count_q, count_d;
  logic [skc_pkg::ModeW-1:0]       mode_q;
  logic signed [skc_pkg::KeyW-1:0] key_q;
  logic                            out_valid_q;
  logic [skc_pkg::StatusW-1:0]     status_q, status_d;
  logic [skc_pkg::EntryW-1:0]      entry_q;

  logic signed [skc_pkg::KeyW-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]             cell_lt, cell_eq, cell_occ;

  logic accept, out_free, commit, found, full;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign commit   = (state_q == skc_pkg::S_UPD) && out_free;
  assign found    = |cell_eq;
  assign full     = (count_q == CntW'(CAPACITY));

  assign in_i.ready = (state_q == skc_pkg::S_IDLE);

  always_comb begin
    ctl.cap  = accept;
    ctl.ins  = commit && (mode_q == skc_pkg::MODE_INSERT) && !found && !full;
    ctl.del  = commit && (mode_q == skc_pkg::MODE_DELETE) && found;
    count_d  = count_q;
    if (ctl.ins) count_d = count_q + 1'b1;
    if (ctl.del) count_d = count_q - 1'b1;
    case (mode_q)
      skc_pkg::MODE_INSERT: begin
        status_d = found ? skc_pkg::ST_DUP : (full ? skc_pkg::ST_FULL : skc_pkg::ST_OK);
      end
      default: begin
        status_d = found ? skc_pkg::ST_OK : skc_pkg::ST_NOTFOUND;
      end
    endcase
    state_d = state_q;
    case (state_q)
      skc_pkg::S_IDLE: if (accept) state_d = skc_pkg::S_UPD;
      skc_pkg::S_UPD:  if (commit) state_d = skc_pkg::S_IDLE;
      default:         state_d = skc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skc_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_i.mode;
      key_q  <= in_i.key;
    end
    if (commit) begin
      status_q <= status_d;
      entry_q  <= skc_pkg::EntryW'(count_d);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.entry_count = entry_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [skc_pkg::KeyW-1:0] prev_key, next_key;
    logic                            prev_lt;

    assign cell_occ[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_head
      assign prev_key = key_q;
      assign prev_lt  = 1'b1;  // head takes the new key unless it stays put
    end else begin : g_mid
      assign prev_key = cell_key[g-1];
      assign prev_lt  = cell_lt[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_key = cell_key[g];
    end else begin : g_body
      assign next_key = cell_key[g+1];
    end

    skc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .occ_i      (cell_occ[g]),
      .cmp_key_i  (in_i.key),
      .new_key_i  (key_q),
      .prev_key_i (prev_key),
      .prev_lt_i  (prev_lt),
      .next_key_i (next_key),
      .key_o      (cell_key[g]),
      .lt_o       (cell_lt[g]),
      .eq_o       (cell_eq[g])
    );
  end

endmodule
